/* rtl/opr_pkg.sv */
// opr_pkg: shared types, fixed-point constants and the arctangent table
// for the orbit point rotation step block
// no dependencies
package opr_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int CFG_IDX_W = 3;
	localparam int TW = 36;
	localparam int XW = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ANGVEL_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGVEL_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGVEL_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd5;

	localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;
	localparam logic signed [TW-1:0] TWO_PI_Q32 = 36'sd26986075409;
	localparam logic signed [TW-1:0] PI_Q32 = 36'sd13493037705;
	localparam logic signed [TW-1:0] HALF_PI_Q32 = 36'sd6746518852;
	localparam logic signed [XW-1:0] GAIN_Q29 = 32'sd326016437;
	localparam logic signed [XW-1:0] ONE_Q29 = 32'sd536870912;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [15:0] step_time;
	} opr_in_t;

	typedef struct packed {
		logic signed [31:0] new_x;
		logic signed [31:0] new_y;
		logic signed [31:0] new_z;
	} opr_out_t;

	// item travelling alongside the angle pipeline
	typedef struct packed {
		logic vld;
		logic neg;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] dz;
	} opr_side_t;

	// values derived from the configuration, static while items flow
	typedef struct packed {
		logic [31:0] spd;
		logic slow;
		logic signed [31:0] k_x;
		logic signed [31:0] k_y;
		logic signed [31:0] k_z;
		logic signed [31:0] cen_x;
		logic signed [31:0] cen_y;
		logic signed [31:0] cen_z;
	} opr_axis_t;

	function automatic logic [31:0] atan_q32(input int idx);
		logic [31:0] v;
		case (idx)
			0: v = 32'd3373259426;
			1: v = 32'd1991351318;
			2: v = 32'd1052175346;
			3: v = 32'd534100635;
			4: v = 32'd268086748;
			5: v = 32'd134174063;
			6: v = 32'd67103403;
			7: v = 32'd33553749;
			8: v = 32'd16777131;
			9: v = 32'd8388597;
			10: v = 32'd4194303;
			11: v = 32'd2097152;
			12: v = 32'd1048576;
			13: v = 32'd524288;
			14: v = 32'd262144;
			15: v = 32'd131072;
			16: v = 32'd65536;
			17: v = 32'd32768;
			18: v = 32'd16384;
			19: v = 32'd8192;
			20: v = 32'd4096;
			21: v = 32'd2048;
			22: v = 32'd1024;
			23: v = 32'd512;
			24: v = 32'd256;
			25: v = 32'd128;
			26: v = 32'd64;
			27: v = 32'd32;
			28: v = 32'd16;
			29: v = 32'd8;
			30: v = 32'd4;
			31: v = 32'd2;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

/* rtl/opr_cfg.sv */
// opr_cfg: configuration registers and the setup sequencer that derives
// speed and unit axis (radian conversion, bit-serial sqrt, serial divide)
// depends on opr_pkg
module opr_cfg import opr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data,
	output logic seq_busy,
	output opr_axis_t axis
);

	localparam logic [31:0] SPEED_MIN = 32'((64'd1 << (FRAC_BITS + 5)) / 64'd1000000);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CONV = 3'd1;
	localparam logic [2:0] S_SQ = 3'd2;
	localparam logic [2:0] S_SQRT = 3'd3;
	localparam logic [2:0] S_DIV = 3'd4;

	logic [2:0] state_q;
	logic [4:0] cnt_q;
	logic [1:0] comp_q;
	logic [1:0] comp_nx;
	logic signed [31:0] angvel_q [3];
	logic signed [31:0] center_q [3];
	logic [26:0] wmag_q [3];
	logic wneg_q [3];
	logic signed [31:0] k_q [3];
	logic [53:0] sum_q;
	logic [63:0] v_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [31:0] spd_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;

	logic wr;
	logic av_wr;
	logic [31:0] mag;
	logic [59:0] rad;
	logic [53:0] sq;
	logic [53:0] sum_n;
	logic [63:0] rb;
	logic sq_ge;
	logic [63:0] r_n;
	logic [32:0] rs;
	logic [32:0] rsub;
	logic dge;
	logic [31:0] rem_n;
	logic [31:0] quo_n;

	assign cfg_ready = (state_q == S_IDLE);
	assign seq_busy = (state_q != S_IDLE);
	assign wr = cfg_valid && cfg_ready;
	assign av_wr = wr && (cfg_index == REG_ANGVEL_X || cfg_index == REG_ANGVEL_Y
		|| cfg_index == REG_ANGVEL_Z);

	always_comb begin
		comp_nx = (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
		mag = angvel_q[comp_q][31] ? 32'(-angvel_q[comp_q]) : 32'(angvel_q[comp_q]);
		rad = 60'(mag) * 60'(DEG2RAD_Q32) + 60'h0_0000_8000_0000;
		sq = 54'(wmag_q[comp_q]) * 54'(wmag_q[comp_q]);
		sum_n = sum_q + sq;
		rb = r_q + bit_q;
		sq_ge = (v_q >= rb);
		r_n = sq_ge ? ((r_q >> 1) + bit_q) : (r_q >> 1);
		rs = {rem_q, 1'b0};
		rsub = rs - {1'b0, spd_q};
		dge = (rs >= {1'b0, spd_q});
		rem_n = dge ? rsub[31:0] : rs[31:0];
		quo_n = {quo_q[30:0], dge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			comp_q <= '0;
			spd_q <= '0;
			for (int i = 0; i < 3; i++) begin
				angvel_q[i] <= '0;
				center_q[i] <= '0;
			end
		end else begin
			if (wr) begin
				unique case (cfg_index)
					REG_ANGVEL_X: angvel_q[0] <= cfg_data;
					REG_ANGVEL_Y: angvel_q[1] <= cfg_data;
					REG_ANGVEL_Z: angvel_q[2] <= cfg_data;
					REG_CENTER_X: center_q[0] <= cfg_data;
					REG_CENTER_Y: center_q[1] <= cfg_data;
					REG_CENTER_Z: center_q[2] <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (av_wr) begin
						state_q <= S_CONV;
						comp_q <= '0;
					end
				end
				S_CONV: begin
					comp_q <= comp_nx;
					if (comp_q == 2'd2) state_q <= S_SQ;
				end
				S_SQ: begin
					comp_q <= comp_nx;
					cnt_q <= '0;
					if (comp_q == 2'd2) state_q <= S_SQRT;
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						spd_q <= r_n[31:0];
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						comp_q <= comp_nx;
						if (comp_q == 2'd2) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_CONV: begin
				wmag_q[comp_q] <= rad[58:32];
				wneg_q[comp_q] <= angvel_q[comp_q][31];
				sum_q <= '0;
			end
			S_SQ: begin
				sum_q <= sum_n;
				if (comp_q == 2'd2) begin
					v_q <= {sum_n, 10'b0};
					r_q <= '0;
					bit_q <= 64'd1 << 62;
				end
			end
			S_SQRT: begin
				if (sq_ge) v_q <= v_q - rb;
				r_q <= r_n;
				bit_q <= bit_q >> 2;
				rem_q <= {2'b0, wmag_q[0], 3'b0};
				quo_q <= '0;
			end
			S_DIV: begin
				if (cnt_q == 5'd31) begin
					k_q[comp_q] <= wneg_q[comp_q] ? -$signed(quo_n) : $signed(quo_n);
					rem_q <= {2'b0, wmag_q[comp_nx], 3'b0};
					quo_q <= '0;
				end else begin
					rem_q <= rem_n;
					quo_q <= quo_n;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		axis.spd = spd_q;
		axis.slow = (spd_q <= SPEED_MIN);
		axis.k_x = k_q[0];
		axis.k_y = k_q[1];
		axis.k_z = k_q[2];
		axis.cen_x = center_q[0];
		axis.cen_y = center_q[1];
		axis.cen_z = center_q[2];
	end

endmodule

/* rtl/opr_mod_cell.sv */
// opr_mod_cell: one cell of the angle reduction chain, takes off two pi
// shifted left by STEP if it fits
// depends on opr_pkg
module opr_mod_cell import opr_pkg::*; #(
	parameter int ANG_W = 48,
	parameter int STEP = 0
) (
	input logic clk,
	input logic arst_n,
	input logic [ANG_W-1:0] ang,
	input opr_side_t side,
	output logic [ANG_W-1:0] ang_q,
	output opr_side_t side_q
);

	localparam logic [ANG_W-1:0] SUB = ANG_W'($unsigned(TWO_PI_Q32)) << STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
			ang_q <= '0;
		end else begin
			side_q <= side;
			ang_q <= (ang >= SUB) ? ang - SUB : ang;
		end
	end

endmodule

/* rtl/opr_cordic_cell.sv */
// opr_cordic_cell: one rotation-mode cordic iteration with its fixed
// arctangent and shift
// depends on opr_pkg
module opr_cordic_cell import opr_pkg::*; #(
	parameter int IDX = 0
) (
	input logic clk,
	input logic arst_n,
	input logic signed [XW-1:0] x,
	input logic signed [XW-1:0] y,
	input logic signed [TW-1:0] t,
	input opr_side_t side,
	output logic signed [XW-1:0] x_q,
	output logic signed [XW-1:0] y_q,
	output logic signed [TW-1:0] t_q,
	output opr_side_t side_q
);

	localparam logic signed [TW-1:0] AT = $signed({{(TW-32){1'b0}}, atan_q32(IDX)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
			x_q <= '0;
			y_q <= '0;
			t_q <= '0;
		end else begin
			side_q <= side;
			if (!t[TW-1]) begin
				x_q <= x - (y >>> IDX);
				y_q <= y + (x >>> IDX);
				t_q <= t - AT;
			end else begin
				x_q <= x + (y >>> IDX);
				y_q <= y - (x >>> IDX);
				t_q <= t + AT;
			end
		end
	end

endmodule

/* rtl/opr_rotate.sv */
// opr_rotate: rodrigues rotation of the centre offset from cos and sin
// (offset passed through when slow), centre add-back and saturation, six register stages
// depends on opr_pkg
module opr_rotate import opr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic signed [XW-1:0] x,
	input logic signed [XW-1:0] y,
	input opr_side_t side,
	input opr_axis_t axis,
	output logic done,
	output opr_out_t result
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [32:0] d_s1 [3];
	logic signed [32:0] d_s2 [3];
	logic signed [32:0] d_s3 [3];
	logic signed [32:0] d_s4 [3];
	logic signed [32:0] d_s5 [3];
	logic signed [30:0] c_s1, s_s1, s_s2, s_s3;
	logic signed [31:0] omc_s1, omc_s2, omc_s3, omc_s4;
	logic signed [33:0] kd_s2 [9];
	logic signed [34:0] dc_s2 [3];
	logic signed [34:0] dc_s3 [3];
	logic signed [34:0] dc_s4 [3];
	logic signed [34:0] dc_s5 [3];
	logic signed [35:0] dot_s3;
	logic signed [34:0] cr_s3 [3];
	logic signed [33:0] kdot_s4 [3];
	logic signed [34:0] crs_s4 [3];
	logic signed [34:0] crs_s5 [3];
	logic signed [34:0] kdo_s5 [3];

	logic signed [31:0] xc, yc, cn, sn;
	logic signed [31:0] ka [9];
	logic signed [32:0] da [9];
	logic signed [64:0] kp [9];
	logic signed [63:0] dp [3];
	logic signed [31:0] kv [3];
	logic signed [31:0] cv [3];
	logic signed [67:0] kdp [3];
	logic signed [65:0] crp [3];
	logic signed [65:0] kop [3];
	logic signed [36:0] sum [3];
	logic signed [31:0] sat [3];

	always_comb begin
		xc = (x > ONE_Q29) ? ONE_Q29 : ((x < -ONE_Q29) ? -ONE_Q29 : x);
		yc = (y > ONE_Q29) ? ONE_Q29 : ((y < -ONE_Q29) ? -ONE_Q29 : y);
		cn = side.neg ? -xc : xc;
		sn = side.neg ? -yc : yc;
		kv[0] = axis.k_x;
		kv[1] = axis.k_y;
		kv[2] = axis.k_z;
		cv[0] = axis.cen_x;
		cv[1] = axis.cen_y;
		cv[2] = axis.cen_z;
		// dot terms, then the three cross product pairs
		ka[0] = axis.k_x; da[0] = d_s1[0];
		ka[1] = axis.k_y; da[1] = d_s1[1];
		ka[2] = axis.k_z; da[2] = d_s1[2];
		ka[3] = axis.k_y; da[3] = d_s1[2];
		ka[4] = axis.k_z; da[4] = d_s1[1];
		ka[5] = axis.k_z; da[5] = d_s1[0];
		ka[6] = axis.k_x; da[6] = d_s1[2];
		ka[7] = axis.k_x; da[7] = d_s1[1];
		ka[8] = axis.k_y; da[8] = d_s1[0];
		for (int i = 0; i < 9; i++) kp[i] = ka[i] * da[i];
		for (int i = 0; i < 3; i++) begin
			dp[i] = d_s1[i] * c_s1;
			kdp[i] = kv[i] * dot_s3;
			crp[i] = cr_s3[i] * s_s3;
			kop[i] = kdot_s4[i] * omc_s4;
			if (axis.slow) sum[i] = cv[i] + d_s5[i];
			else sum[i] = cv[i] + dc_s5[i] + crs_s5[i] + kdo_s5[i];
			if (sum[i] > 37'sd2147483647) sat[i] = 32'sh7fffffff;
			else if (sum[i] < -37'sd2147483648) sat[i] = 32'sh80000000;
			else sat[i] = sum[i][31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			done <= 1'b0;
		end else begin
			vld_s1 <= side.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			done <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		d_s1[0] <= side.dx;
		d_s1[1] <= side.dy;
		d_s1[2] <= side.dz;
		c_s1 <= cn[30:0];
		s_s1 <= sn[30:0];
		omc_s1 <= ONE_Q29 - cn;

		for (int i = 0; i < 9; i++) kd_s2[i] <= $signed(kp[i][63:30]);
		for (int i = 0; i < 3; i++) dc_s2[i] <= $signed(dp[i][63:29]);
		d_s2 <= d_s1;
		s_s2 <= s_s1;
		omc_s2 <= omc_s1;

		dot_s3 <= kd_s2[0] + kd_s2[1] + kd_s2[2];
		cr_s3[0] <= kd_s2[3] - kd_s2[4];
		cr_s3[1] <= kd_s2[5] - kd_s2[6];
		cr_s3[2] <= kd_s2[7] - kd_s2[8];
		dc_s3 <= dc_s2;
		d_s3 <= d_s2;
		s_s3 <= s_s2;
		omc_s3 <= omc_s2;

		for (int i = 0; i < 3; i++) begin
			kdot_s4[i] <= $signed(kdp[i][63:30]);
			crs_s4[i] <= $signed(crp[i][63:29]);
		end
		dc_s4 <= dc_s3;
		d_s4 <= d_s3;
		omc_s4 <= omc_s3;

		for (int i = 0; i < 3; i++) kdo_s5[i] <= $signed(kop[i][63:29]);
		crs_s5 <= crs_s4;
		dc_s5 <= dc_s4;
		d_s5 <= d_s4;

		result.new_x <= sat[0];
		result.new_y <= sat[1];
		result.new_z <= sat[2];
	end

endmodule

/* rtl/orbit_point_rotation_step.sv */
// orbit_point_rotation_step: top level, angle multiply, reduction chain,
// cordic chain and rotation back end
// depends on opr_pkg, opr_cfg, opr_mod_cell, opr_cordic_cell, opr_rotate
//
// One point is taken on every clock edge at which start is high and busy is
// low, and its rotated position appears on result with a one-cycle done
// strobe. The path is fixed: a speed by step multiply, one two-pi reduction
// cell per quotient bit, a fold into plus or minus half pi, one cordic cell
// per step and six stages of rotation. The receiver cannot stall results;
// done must be sampled every cycle. Writing an angular velocity register
// starts a setup (radian scaling, squares, a bit-serial square root and
// three serial divides for the unit axis) during which busy is high and
// cfg_ready is low. Centre writes take effect at once.
module orbit_point_rotation_step import opr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input opr_in_t point,
	output logic busy,
	output logic done,
	output opr_out_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data
);

	localparam int SH = FRAC_BITS - 11;
	localparam int ANG_W = (SH >= 0) ? 48 : 48 - SH;
	localparam int RED_N = ANG_W - 34;

	opr_axis_t axis;
	logic seq_busy;
	logic accept;

	logic [47:0] p_s1;
	opr_side_t side_s1;
	logic signed [TW-1:0] t_s2;
	opr_side_t side_s2;

	logic [ANG_W-1:0] ang_c [RED_N+1];
	opr_side_t side_c [RED_N+1];
	logic signed [XW-1:0] x_c [CORDIC_STEPS+1];
	logic signed [XW-1:0] y_c [CORDIC_STEPS+1];
	logic signed [TW-1:0] t_c [CORDIC_STEPS+1];
	opr_side_t side_k [CORDIC_STEPS+1];

	logic signed [TW-1:0] t_w;
	logic signed [TW-1:0] t_f;
	logic neg_f;

	opr_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.seq_busy(seq_busy),
		.axis(axis)
	);

	assign busy = seq_busy || (cfg_valid && cfg_ready);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_s1 <= '0;
			side_s1 <= '0;
			t_s2 <= '0;
			side_s2 <= '0;
		end else begin
			p_s1 <= 48'(axis.spd) * 48'(point.step_time);
			side_s1.vld <= accept;
			side_s1.neg <= 1'b0;
			side_s1.dx <= 33'(point.pos_x) - 33'(axis.cen_x);
			side_s1.dy <= 33'(point.pos_y) - 33'(axis.cen_y);
			side_s1.dz <= 33'(point.pos_z) - 33'(axis.cen_z);
			t_s2 <= t_f;
			side_s2.vld <= side_c[RED_N].vld;
			side_s2.neg <= neg_f;
			side_s2.dx <= side_c[RED_N].dx;
			side_s2.dy <= side_c[RED_N].dy;
			side_s2.dz <= side_c[RED_N].dz;
		end
	end

	generate
		if (SH >= 0) begin : g_shr
			assign ang_c[0] = ANG_W'(p_s1 >> SH);
		end else begin : g_shl
			assign ang_c[0] = ANG_W'(p_s1) << (-SH);
		end
	endgenerate
	assign side_c[0] = side_s1;

	for (genvar j = 0; j < RED_N; j++) begin : g_red
		opr_mod_cell #(.ANG_W(ANG_W), .STEP(RED_N - 1 - j)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ang(ang_c[j]),
			.side(side_c[j]),
			.ang_q(ang_c[j+1]),
			.side_q(side_c[j+1])
		);
	end

	// fold into plus or minus half pi, sign flip when folded by pi
	always_comb begin
		t_w = $signed({1'b0, ang_c[RED_N][TW-2:0]});
		if (t_w > PI_Q32) t_w = t_w - TWO_PI_Q32;
		neg_f = 1'b0;
		t_f = t_w;
		if (t_w > HALF_PI_Q32) begin
			t_f = t_w - PI_Q32;
			neg_f = 1'b1;
		end else if (t_w < -HALF_PI_Q32) begin
			t_f = t_w + PI_Q32;
			neg_f = 1'b1;
		end
	end

	assign x_c[0] = GAIN_Q29;
	assign y_c[0] = '0;
	assign t_c[0] = t_s2;
	assign side_k[0] = side_s2;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		opr_cordic_cell #(.IDX(i)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.x(x_c[i]),
			.y(y_c[i]),
			.t(t_c[i]),
			.side(side_k[i]),
			.x_q(x_c[i+1]),
			.y_q(y_c[i+1]),
			.t_q(t_c[i+1]),
			.side_q(side_k[i+1])
		);
	end

	opr_rotate u_rotate (
		.clk(clk),
		.arst_n(arst_n),
		.x(x_c[CORDIC_STEPS]),
		.y(y_c[CORDIC_STEPS]),
		.side(side_k[CORDIC_STEPS]),
		.axis(axis),
		.done(done),
		.result(result)
	);

endmodule

/* tb/sv/opr_rotation_checker.sv */
`timescale 1ns / 1ps
// opr_rotation_checker: watches the point, result and configuration channels
// of the orbit point rotation step block, predicts each new position and compares it
// depends on opr_pkg
module opr_rotation_checker import opr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input opr_in_t point,
	input logic done,
	input opr_out_t result,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data,
	output int errors,
	output int pending
);

	localparam longint DEG_TO_RAD = 74961321;
	localparam longint TURN = 64'sd26986075409;
	localparam longint HALF_TURN = 64'sd13493037705;
	localparam longint QUARTER_TURN = 64'sd6746518852;
	localparam longint CORDIC_GAIN = 326016437;
	localparam longint UNIT = 536870912;
	localparam longint unsigned MIN_SPEED = (64'd1 << (FRAC_BITS_DEF + 5)) / 64'd1000000;

	localparam longint ARCTAN [32] = '{
		64'sd3373259426, 1991351318, 1052175346, 534100635,
		268086748, 134174063, 67103403, 33553749,
		16777131, 8388597, 4194303, 2097152,
		1048576, 524288, 262144, 131072,
		65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512,
		256, 128, 64, 32,
		16, 8, 4, 2
	};

	longint omega [3];
	longint centre [3];
	opr_out_t position_q [$];

	function automatic longint deg_to_rad(longint a);
		longint unsigned m;
		longint r;
		m = (a < 0) ? -a : a;
		r = (m * DEG_TO_RAD + 64'h80000000) >> 32;
		return (a < 0) ? -r : r;
	endfunction

	function automatic longint unsigned root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unit_axis(longint w, longint unsigned spd);
		longint unsigned m;
		longint k;
		m = (w < 0) ? -w : w;
		k = (m << 35) / spd;
		return (w < 0) ? -k : k;
	endfunction

	function automatic longint limit_unit(longint v);
		if (v > UNIT) return UNIT;
		if (v < -UNIT) return -UNIT;
		return v;
	endfunction

	function automatic logic signed [31:0] saturate(longint v);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic opr_out_t rotate_point(opr_in_t p);
		opr_out_t o;
		longint w [3];
		longint k [3];
		longint d [3];
		longint cr [3];
		longint n [3];
		longint unsigned sum, spd, ang;
		longint t, x, y, nx, c, s, omc, dot;
		bit neg;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			w[i] = deg_to_rad(omega[i]);
			sum = sum + w[i] * w[i];
		end
		spd = root(sum << 10);
		if (spd <= MIN_SPEED) begin
			o.new_x = p.pos_x;
			o.new_y = p.pos_y;
			o.new_z = p.pos_z;
			return o;
		end
		for (int i = 0; i < 3; i++) k[i] = unit_axis(w[i], spd);
		if (FRAC_BITS_DEF >= 11) ang = (spd * p.step_time) >> (FRAC_BITS_DEF - 11);
		else ang = (spd * p.step_time) << (11 - FRAC_BITS_DEF);
		t = ang % TURN;
		neg = 0;
		if (t > HALF_TURN) t = t - TURN;
		if (t > QUARTER_TURN) begin
			t = t - HALF_TURN;
			neg = 1;
		end else if (t < -QUARTER_TURN) begin
			t = t + HALF_TURN;
			neg = 1;
		end
		x = CORDIC_GAIN;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS_DEF && i < 32; i++) begin
			if (t >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				t = t - ARCTAN[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				t = t + ARCTAN[i];
			end
			x = nx;
		end
		c = limit_unit(x);
		s = limit_unit(y);
		if (neg) begin
			c = -c;
			s = -s;
		end
		omc = UNIT - c;
		d[0] = longint'(p.pos_x) - centre[0];
		d[1] = longint'(p.pos_y) - centre[1];
		d[2] = longint'(p.pos_z) - centre[2];
		dot = ((k[0] * d[0]) >>> 30) + ((k[1] * d[1]) >>> 30) + ((k[2] * d[2]) >>> 30);
		cr[0] = ((k[1] * d[2]) >>> 30) - ((k[2] * d[1]) >>> 30);
		cr[1] = ((k[2] * d[0]) >>> 30) - ((k[0] * d[2]) >>> 30);
		cr[2] = ((k[0] * d[1]) >>> 30) - ((k[1] * d[0]) >>> 30);
		for (int i = 0; i < 3; i++)
			n[i] = centre[i] + ((d[i] * c) >>> 29) + ((cr[i] * s) >>> 29)
				+ ((((k[i] * dot) >>> 30) * omc) >>> 29);
		o.new_x = saturate(n[0]);
		o.new_y = saturate(n[1]);
		o.new_z = saturate(n[2]);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		opr_out_t e;
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				omega[i] = 0;
				centre[i] = 0;
			end
			position_q.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ANGVEL_X: omega[0] = longint'($signed(cfg_data));
					REG_ANGVEL_Y: omega[1] = longint'($signed(cfg_data));
					REG_ANGVEL_Z: omega[2] = longint'($signed(cfg_data));
					REG_CENTER_X: centre[0] = longint'($signed(cfg_data));
					REG_CENTER_Y: centre[1] = longint'($signed(cfg_data));
					REG_CENTER_Z: centre[2] = longint'($signed(cfg_data));
					default: ;
				endcase
			end
			if (start && !busy) position_q.push_back(rotate_point(point));
			if (done) begin
				if (position_q.size() == 0) begin
					$error("result with no item outstanding");
					errors <= errors + 1;
				end else begin
					e = position_q.pop_front();
					if (e !== result) begin
						errors <= errors + 1;
						if (e.new_x !== result.new_x)
							$error("new_x expected %0d got %0d", e.new_x, result.new_x);
						if (e.new_y !== result.new_y)
							$error("new_y expected %0d got %0d", e.new_y, result.new_y);
						if (e.new_z !== result.new_z)
							$error("new_z expected %0d got %0d", e.new_z, result.new_z);
					end
				end
			end
			pending <= position_q.size();
		end
	end

endmodule

/* tb/sv/tb_orbit_point_rotation_step.sv */
`timescale 1ns / 1ps
// tb_orbit_point_rotation_step: drives points and configuration phases into the
// orbit point rotation step block and gives the verdict
// depends on opr_pkg, orbit_point_rotation_step, opr_rotation_checker
module tb_orbit_point_rotation_step import opr_pkg::*;;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	opr_in_t point = '0;
	logic busy, done, cfg_ready;
	opr_out_t result;
	logic cfg_valid = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int errors, pending;
	int quiet_cycles = 0;
	int idle_pct = 0;

	orbit_point_rotation_step dut (
		.clk(clk), .arst_n(arst_n), .start(start), .point(point), .busy(busy),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	opr_rotation_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .point(point),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors), .pending(pending)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 5000) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		bit ok;
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		ok = cfg_ready;
		@(negedge clk);
		while (!ok) begin
			ok = cfg_ready;
			@(negedge clk);
		end
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	task automatic send_point(opr_in_t p);
		bit ok;
		start <= 1;
		point <= p;
		ok = !busy;
		@(negedge clk);
		while (!ok) begin
			ok = !busy;
			@(negedge clk);
		end
		if ($urandom_range(99) < idle_pct) begin
			start <= 0;
			do @(negedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(2000000) - 1000000;
			2: return {{8{1'b0}}, 24'($urandom)} - 32'h00800000;
			default: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(255)
				: 32'h80000000 + $urandom_range(255);
		endcase
	endfunction

	function automatic opr_in_t rand_point();
		opr_in_t p;
		p.pos_x = rand_coord();
		p.pos_y = rand_coord();
		p.pos_z = rand_coord();
		p.step_time = $urandom_range(3) == 0 ? 16'($urandom_range(255)) : 16'($urandom);
		return p;
	endfunction

	task automatic drain();
		start <= 0;
		@(negedge clk);
		while (pending != 0 || (start && !busy)) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_phase(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
		logic [31:0] cx, logic [31:0] cy, logic [31:0] cz, bit directed, int mode);
		opr_in_t p;
		write_reg(REG_ANGVEL_X, ax);
		write_reg(REG_ANGVEL_Y, ay);
		write_reg(REG_ANGVEL_Z, az);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_CENTER_Z, cz);
		case (mode)
			0: idle_pct = 0;
			1: idle_pct = 85;
			default: idle_pct = 24;
		endcase
		if (directed) begin
			send_point('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16'hffff});
			send_point('{-32'sh80000000, -32'sh80000000, -32'sh80000000, 16'hffff});
			send_point('{32'sh7fffffff, -32'sh80000000, 0, 16'h8000});
			send_point('{32'sh00010000, 32'sh00020000, -32'sh00030000, 16'h0000});
			send_point('{cx, cy, cz, 16'h4000});
			send_point('{32'sh00100000, 0, 0, 16'h0001});
			send_point('{0, 32'sh00100000, 0, 16'h7fff});
			send_point('{0, 0, -32'sh00100000, 16'hffff});
		end
		for (int i = 0; i < 212; i++) begin
			p = rand_point();
			send_point(p);
		end
		drain();
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// zero spin, then just under and just over the pass-through speed
		run_phase(0, 0, 0, 0, 0, 0, 0, 0);
		write_reg(3'd6, $urandom);
		write_reg(3'd7, $urandom);
		run_phase(32'd28, -32'sd28, 32'd28, $urandom, $urandom, $urandom, 0, 1);
		run_phase(32'd29, 0, 0, 32'h00050000, -32'sh00030000, 0, 1, 2);
		run_phase(32'h7fffffff, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h80000000, 32'h7fffffff, 1, 0);
		run_phase(0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 3);
		run_phase($urandom, $urandom, $urandom, rand_coord(), rand_coord(), rand_coord(), 0, 1);
		run_phase($urandom_range(200000) - 100000, $urandom_range(200000) - 100000,
			$urandom_range(200000) - 100000, rand_coord(), rand_coord(), rand_coord(), 0, 2);
		run_phase($urandom, 0, $urandom, 0, 0, 0, 0, 0);
		repeat (60) @(negedge clk);
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule
